[rtl/core/lflc_pkg.sv]
// Shared types and codes for the linear frame layout checker.
// Stage record types, status codes and pixel format codes.
// No dependencies.
`default_nettype none
package lflc_pkg;

   localparam logic [2:0] FMT_NV12     = 3'd0;
   localparam logic [2:0] FMT_NV16     = 3'd1;
   localparam logic [2:0] FMT_YUYV     = 3'd2;
   localparam logic [2:0] FMT_RGB565   = 3'd3;
   localparam logic [2:0] FMT_RGB888   = 3'd4;
   localparam logic [2:0] FMT_ARGB8888 = 3'd5;
   localparam logic [2:0] FMT_BGRA8888 = 3'd6;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_SIZE  = 3'd1;
   localparam logic [2:0] ST_BAD_WIDTH  = 3'd2;
   localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
   localparam logic [2:0] ST_SHORT_PITCH = 3'd4;
   localparam logic [2:0] ST_OFFSET_OVF = 3'd5;
   localparam logic [2:0] ST_OVERLAP    = 3'd6;
   localparam logic [2:0] ST_TOO_SMALL  = 3'd7;

   localparam logic [31:0] U32_ALL     = 32'hFFFF_FFFF;
   localparam logic [31:0] WIDTH_MAX_2 = U32_ALL / 32'd2;
   localparam logic [31:0] WIDTH_MAX_3 = U32_ALL / 32'd3;
   localparam logic [31:0] WIDTH_MAX_4 = U32_ALL / 32'd4;

   typedef struct packed {
      logic [2:0]  pixel_format;
      logic [31:0] frame_width;
      logic [31:0] frame_height;
      logic        pitches_given;
      logic [31:0] pitch_in_first;
      logic [31:0] pitch_in_second;
      logic        offsets_given;
      logic [31:0] offset_in_first;
      logic [31:0] offset_in_second;
      logic [63:0] buffer_bytes;
   } desc_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        two_planes;
      logic        offsets_given;
      logic [31:0] line_len0;
      logic [31:0] line_len1;
      logic [31:0] pitch0;
      logic [31:0] pitch1;
      logic [31:0] rows0_m1;
      logic [31:0] rows1_m1;
      logic [31:0] offset_in0;
      logic [31:0] offset_in1;
      logic [63:0] buffer_bytes;
   } dec_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        two_planes;
      logic        offsets_given;
      logic [31:0] line_len0;
      logic [31:0] line_len1;
      logic [31:0] pitch0;
      logic [31:0] pitch1;
      logic [63:0] span0;
      logic [63:0] span1;
      logic [31:0] offset_in0;
      logic [31:0] offset_in1;
      logic [63:0] buffer_bytes;
   } mul_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        two_planes;
      logic [31:0] pitch0;
      logic [31:0] pitch1;
      logic [31:0] offset0;
      logic [31:0] offset1;
      logic [63:0] end0;
      logic [63:0] end1;
      logic [63:0] buffer_bytes;
   } place_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  num_planes;
      logic [31:0] pitch_out_first;
      logic [31:0] pitch_out_second;
      logic [31:0] offset_out_first;
      logic [31:0] offset_out_second;
      logic [63:0] required_bytes;
   } result_type;

endpackage
`default_nettype wire

[rtl/core/linear_frame_layout_checker_top.sv]
// Linear frame layout checker: six register stages, decode, multiply,
// packed offset, plane ends, overlap, size check with result register.
// Throughput: one transaction per cycle while rsp_tready is high; each stage holds while the next is full.
// Reset clears every stage valid bit; payload registers are not reset.
`default_nettype none
module linear_frame_layout_checker_top
   import lflc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pixel_format, frame_width, frame_height, pitches_given, pitch_in_first,
   // pitch_in_second, offsets_given, offset_in_first, offset_in_second,
   // buffer_bytes, zero fill
   input  wire logic [263:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, num_planes, pitch_out_first, pitch_out_second,
   // offset_out_first, offset_out_second, required_bytes, zero fill
   output logic [199:0]      rsp_tdata
);

   desc_type   desc;
   dec_type    dec;
   mul_type    mul;
   place_type  place;
   result_type result;

   logic dec_valid;
   logic dec_ready;
   logic mul_valid;
   logic mul_ready;
   logic place_valid;
   logic place_ready;

   always_comb begin
      desc.pixel_format     = req_tdata[2:0];
      desc.frame_width      = req_tdata[34:3];
      desc.frame_height     = req_tdata[66:35];
      desc.pitches_given    = req_tdata[67];
      desc.pitch_in_first   = req_tdata[99:68];
      desc.pitch_in_second  = req_tdata[131:100];
      desc.offsets_given    = req_tdata[132];
      desc.offset_in_first  = req_tdata[164:133];
      desc.offset_in_second = req_tdata[196:165];
      desc.buffer_bytes     = req_tdata[260:197];
   end

   lflc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_desc   (desc),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_dec   (dec)
   );

   lflc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_dec    (dec),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_mul   (mul)
   );

   lflc_place u_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (mul_ready),
      .in_mul    (mul),
      .out_valid (place_valid),
      .out_ready (place_ready),
      .out_place (place)
   );

   lflc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (place_valid),
      .in_ready   (place_ready),
      .in_place   (place),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'd0, result.required_bytes, result.offset_out_second,
                       result.offset_out_first, result.pitch_out_second,
                       result.pitch_out_first, result.num_planes, result.status};

endmodule
`default_nettype wire

[rtl/core/lflc_decode.sv]
// First stage: format decode, width checks, row bytes and pitch selection.
// Depends on lflc_pkg.
`default_nettype none
module lflc_decode
   import lflc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire desc_type in_desc,
   output logic          out_valid,
   input  wire logic     out_ready,
   output dec_type       out_dec
);

   logic    valid_ff;
   dec_type dec_ff;
   dec_type dec_in;

   logic [31:0] w;
   logic [31:0] h;
   logic [33:0] w_x2;
   logic [33:0] w_x3;
   logic [33:0] w_x4;
   logic        bad_fmt;
   logic        bad_width;
   logic        two_planes;
   logic [31:0] rb0;
   logic [31:0] rb1;
   logic [31:0] rows1;
   logic [31:0] p0;
   logic [31:0] p1;
   logic [2:0]  status;

   always_comb begin
      w     = in_desc.frame_width;
      h     = in_desc.frame_height;
      w_x2  = {2'b00, w} << 1;
      w_x4  = {2'b00, w} << 2;
      w_x3  = w_x2 + {2'b00, w};
      bad_fmt    = 1'b0;
      bad_width  = 1'b0;
      two_planes = 1'b0;
      rb0   = w;
      rb1   = 32'd0;
      rows1 = 32'd0;
      case (in_desc.pixel_format)
         FMT_NV12: begin
            bad_width  = w[0] | h[0];
            two_planes = 1'b1;
            rb1        = w;
            rows1      = h >> 1;
         end
         FMT_NV16: begin
            bad_width  = w[0];
            two_planes = 1'b1;
            rb1        = w;
            rows1      = h;
         end
         FMT_YUYV: begin
            bad_width = w[0] | (w > WIDTH_MAX_2);
            rb0       = w_x2[31:0];
         end
         FMT_RGB565: begin
            bad_width = w > WIDTH_MAX_2;
            rb0       = w_x2[31:0];
         end
         FMT_RGB888: begin
            bad_width = w > WIDTH_MAX_3;
            rb0       = w_x3[31:0];
         end
         FMT_ARGB8888, FMT_BGRA8888: begin
            bad_width = w > WIDTH_MAX_4;
            rb0       = w_x4[31:0];
         end
         default: begin
            bad_fmt = 1'b1;
         end
      endcase

      p0 = in_desc.pitches_given ? in_desc.pitch_in_first : rb0;
      p1 = two_planes ? (in_desc.pitches_given ? in_desc.pitch_in_second : rb1) : 32'd0;

      if (w == 32'd0 || h == 32'd0) begin
         status = ST_ZERO_SIZE;
      end else if (bad_fmt) begin
         status = ST_BAD_FORMAT;
      end else if (bad_width) begin
         status = ST_BAD_WIDTH;
      end else if (p0 < rb0 || (two_planes && p1 < rb1)) begin
         status = ST_SHORT_PITCH;
      end else begin
         status = ST_OK;
      end

      dec_in.status        = status;
      dec_in.two_planes    = two_planes;
      dec_in.offsets_given = in_desc.offsets_given;
      dec_in.line_len0     = rb0;
      dec_in.line_len1     = rb1;
      dec_in.pitch0        = p0;
      dec_in.pitch1        = p1;
      dec_in.rows0_m1      = h - 32'd1;
      dec_in.rows1_m1      = two_planes ? rows1 - 32'd1 : 32'd0;
      dec_in.offset_in0    = in_desc.offset_in_first;
      dec_in.offset_in1    = in_desc.offset_in_second;
      dec_in.buffer_bytes  = in_desc.buffer_bytes;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dec_ff <= dec_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/lflc_mult.sv]
// Second stage: pitch times rows-minus-one for both planes.
// Depends on lflc_pkg.
`default_nettype none
module lflc_mult
   import lflc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire dec_type in_dec,
   output logic         out_valid,
   input  wire logic    out_ready,
   output mul_type      out_mul
);

   logic    valid_ff;
   mul_type mul_ff;
   mul_type mul_in;

   always_comb begin
      mul_in.status        = in_dec.status;
      mul_in.two_planes    = in_dec.two_planes;
      mul_in.offsets_given = in_dec.offsets_given;
      mul_in.line_len0     = in_dec.line_len0;
      mul_in.line_len1     = in_dec.line_len1;
      mul_in.pitch0        = in_dec.pitch0;
      mul_in.pitch1        = in_dec.pitch1;
      mul_in.span0         = {32'd0, in_dec.pitch0} * {32'd0, in_dec.rows0_m1};
      mul_in.span1         = {32'd0, in_dec.pitch1} * {32'd0, in_dec.rows1_m1};
      mul_in.offset_in0    = in_dec.offset_in0;
      mul_in.offset_in1    = in_dec.offset_in1;
      mul_in.buffer_bytes  = in_dec.buffer_bytes;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_mul   = mul_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mul_ff <= mul_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/lflc_place.sv]
// Third and fourth stages: packed offset with overflow check, then plane ends.
// Depends on lflc_pkg.
`default_nettype none
module lflc_place
   import lflc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire mul_type in_mul,
   output logic         out_valid,
   input  wire logic    out_ready,
   output place_type    out_place
);

   // stage three holds partial ends, stage four the full ends
   logic        valid_a_ff;
   logic        ready_a;
   logic [2:0]  status_a_ff;
   logic        two_a_ff;
   logic [31:0] p0_a_ff;
   logic [31:0] p1_a_ff;
   logic [31:0] o0_a_ff;
   logic [31:0] o1_a_ff;
   logic [63:0] part0_a_ff;
   logic [63:0] part1_a_ff;
   logic [63:0] buf_a_ff;

   logic [63:0] second;
   logic [31:0] o1_sel;
   logic [2:0]  status_a_in;

   logic        valid_b_ff;
   place_type   place_ff;
   place_type   place_in;

   always_comb begin
      second = in_mul.span0 + {32'd0, in_mul.pitch0};
      if (in_mul.offsets_given) begin
         o1_sel = in_mul.offset_in1;
      end else if (in_mul.two_planes) begin
         o1_sel = second[31:0];
      end else begin
         o1_sel = 32'd0;
      end
      if (in_mul.status == ST_OK && !in_mul.offsets_given && in_mul.two_planes &&
          second[63:32] != 32'd0) begin
         status_a_in = ST_OFFSET_OVF;
      end else begin
         status_a_in = in_mul.status;
      end
   end

   assign ready_a  = !valid_b_ff || out_ready;
   assign in_ready = !valid_a_ff || ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (in_ready) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         status_a_ff <= status_a_in;
         two_a_ff    <= in_mul.two_planes;
         p0_a_ff     <= in_mul.pitch0;
         p1_a_ff     <= in_mul.pitch1;
         o0_a_ff     <= in_mul.offsets_given ? in_mul.offset_in0 : 32'd0;
         o1_a_ff     <= o1_sel;
         part0_a_ff  <= in_mul.span0 + {32'd0, in_mul.line_len0};
         part1_a_ff  <= in_mul.span1 + {32'd0, in_mul.line_len1};
         buf_a_ff    <= in_mul.buffer_bytes;
      end
   end

   always_comb begin
      place_in.status       = status_a_ff;
      place_in.two_planes   = two_a_ff;
      place_in.pitch0       = p0_a_ff;
      place_in.pitch1       = p1_a_ff;
      place_in.offset0      = o0_a_ff;
      place_in.offset1      = o1_a_ff;
      place_in.end0         = part0_a_ff + {32'd0, o0_a_ff};
      place_in.end1         = two_a_ff ? part1_a_ff + {32'd0, o1_a_ff} : 64'd0;
      place_in.buffer_bytes = buf_a_ff;
   end

   assign out_valid = valid_b_ff;
   assign out_place = place_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_a) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && valid_a_ff) begin
         place_ff <= place_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/lflc_check.sv]
// Fifth and sixth stages: overlap check and largest end, then size check
// and the result register. Depends on lflc_pkg.
`default_nettype none
module lflc_check
   import lflc_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire place_type in_place,
   output logic           out_valid,
   input  wire logic      out_ready,
   output result_type     out_result
);

   logic        valid_a_ff;
   logic        ready_a;
   logic [2:0]  status_a_ff;
   logic        two_a_ff;
   logic [31:0] p0_a_ff;
   logic [31:0] p1_a_ff;
   logic [31:0] o0_a_ff;
   logic [31:0] o1_a_ff;
   logic [63:0] req_a_ff;
   logic [63:0] buf_a_ff;
   logic [2:0]  status_a_in;

   logic        valid_b_ff;
   result_type  result_ff;
   result_type  result_in;
   logic [2:0]  status_b;

   always_comb begin
      if (in_place.status == ST_OK && in_place.two_planes &&
          {32'd0, in_place.offset1} < in_place.end0) begin
         status_a_in = ST_OVERLAP;
      end else begin
         status_a_in = in_place.status;
      end
   end

   assign ready_a  = !valid_b_ff || out_ready;
   assign in_ready = !valid_a_ff || ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (in_ready) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         status_a_ff <= status_a_in;
         two_a_ff    <= in_place.two_planes;
         p0_a_ff     <= in_place.pitch0;
         p1_a_ff     <= in_place.pitch1;
         o0_a_ff     <= in_place.offset0;
         o1_a_ff     <= in_place.offset1;
         req_a_ff    <= (in_place.end0 > in_place.end1) ? in_place.end0 : in_place.end1;
         buf_a_ff    <= in_place.buffer_bytes;
      end
   end

   always_comb begin
      if (status_a_ff == ST_OK && buf_a_ff != 64'd0 && req_a_ff > buf_a_ff) begin
         status_b = ST_TOO_SMALL;
      end else begin
         status_b = status_a_ff;
      end
      result_in = '0;
      result_in.status = status_b;
      if (status_b == ST_OK) begin
         result_in.num_planes        = two_a_ff ? 2'd2 : 2'd1;
         result_in.pitch_out_first   = p0_a_ff;
         result_in.pitch_out_second  = p1_a_ff;
         result_in.offset_out_first  = o0_a_ff;
         result_in.offset_out_second = o1_a_ff;
         result_in.required_bytes    = req_a_ff;
      end
   end

   assign out_valid  = valid_b_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_a) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && valid_a_ff) begin
         result_ff <= result_in;
      end
   end

endmodule
`default_nettype wire
